[rtl/xds_pkg.sv]
// xds_pkg: shared types, sizes and codes of the xor distance shortlist
// no dependencies; used by every other file of the block

package xds_pkg;

    localparam int LIST_DEPTH = 64;
    localparam int ID_BYTES   = 20;
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int ID_W       = 160;
    localparam int ID_KEEP    = (ID_BYTES * 8 > ID_W) ? ID_W : ID_BYTES * 8;
    localparam logic [ID_W-1:0] ID_MASK = {ID_W{1'b1}} << (ID_W - ID_KEEP);

    localparam int CFG_IDX_W = 8;
    localparam logic [7:0] HOP_LIMIT_RESET = 8'd48;
    localparam logic [6:0] TOP_COUNT_RESET = 7'd20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_HIGH   = 8'd0,
        REG_TARGET_MIDDLE = 8'd1,
        REG_TARGET_LOW    = 8'd2,
        REG_OWN_FAMILY    = 8'd3,
        REG_HOP_LIMIT     = 8'd4,
        REG_TOP_COUNT     = 8'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        MODE_INSERT   = 2'd0,
        MODE_PICK     = 2'd1,
        MODE_COMPLETE = 2'd2,
        MODE_CLEAR    = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_INSERTED      = 4'd0,
        ST_PRESENT       = 4'd1,
        ST_WRONG_FAMILY  = 4'd2,
        ST_REJECTED_FULL = 4'd3,
        ST_PICKED        = 4'd4,
        ST_NONE_FRESH    = 4'd5,
        ST_BUSY          = 4'd6,
        ST_COMPLETED     = 4'd7,
        ST_NONE_PENDING  = 4'd8,
        ST_CLEARED       = 4'd9
    } status_t;

    typedef enum logic [1:0] {
        PROBE_FRESH     = 2'd0,
        PROBE_INFLIGHT  = 2'd1,
        PROBE_RESPONDED = 2'd2,
        PROBE_FAILED    = 2'd3
    } probe_t;

    typedef struct packed {
        logic [31:0] id_high;
        logic [63:0] id_middle;
        logic [63:0] id_low;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [15:0] port;
        logic        has_id;
        probe_t      pstate;
    } slot_t;

endpackage

[rtl/xds_if.sv]
// xds_if: valid/ready channel interfaces of the shortlist (request, result, config)
// depends on xds_pkg

interface xds_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic        peer_is_v6;
    logic [63:0] peer_address_high;
    logic [63:0] peer_address_low;
    logic [15:0] peer_port;
    logic        id_present;
    logic [31:0] node_id_high;
    logic [63:0] node_id_middle;
    logic [63:0] node_id_low;
    logic        responded;

    modport source (output valid, mode, peer_is_v6, peer_address_high, peer_address_low,
                    peer_port, id_present, node_id_high, node_id_middle, node_id_low,
                    responded, input ready);
    modport sink (input valid, mode, peer_is_v6, peer_address_high, peer_address_low,
                  peer_port, id_present, node_id_high, node_id_middle, node_id_low,
                  responded, output ready);
endinterface

interface xds_out_if;
    logic                    valid;
    logic                    ready;
    logic [3:0]              status;
    logic [xds_pkg::CNT_W-1:0] entry_index;
    logic [63:0]             out_address_high;
    logic [63:0]             out_address_low;
    logic [15:0]             out_port;
    logic [xds_pkg::CNT_W-1:0] entry_count;
    logic                    walk_done;
    logic [7:0]              hop_count;

    modport source (output valid, status, entry_index, out_address_high, out_address_low,
                    out_port, entry_count, walk_done, hop_count, input ready);
    modport sink (input valid, status, entry_index, out_address_high, out_address_low,
                  out_port, entry_count, walk_done, hop_count, output ready);
endinterface

interface xds_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [xds_pkg::CFG_IDX_W-1:0] index;
    logic [63:0]                   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/xds_slot_ram.sv]
// xds_slot_ram: shortlist entry memory, one write and one registered read per cycle
// depends on xds_pkg

module xds_slot_ram (
    input  logic                      clk,
    input  logic                      we,
    input  logic [xds_pkg::IDX_W-1:0] waddr,
    input  xds_pkg::slot_t            wdata,
    input  logic [xds_pkg::IDX_W-1:0] raddr,
    output xds_pkg::slot_t            rdata
);

    xds_pkg::slot_t mem [xds_pkg::LIST_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/xds_dist_cmp.sv]
// xds_dist_cmp: shared xor distance comparator, true when a sorts strictly before b
// depends on xds_pkg

module xds_dist_cmp (
    input  logic [xds_pkg::ID_W-1:0] target,
    input  xds_pkg::slot_t           a,
    input  xds_pkg::slot_t           b,
    output logic                     a_less
);

    logic [xds_pkg::ID_W-1:0] da;
    logic [xds_pkg::ID_W-1:0] db;

    always_comb
    begin
        da = ({a.id_high, a.id_middle, a.id_low} ^ target) & xds_pkg::ID_MASK;
        db = ({b.id_high, b.id_middle, b.id_low} ^ target) & xds_pkg::ID_MASK;
        // entries without an id sort after all entries with one
        if (a.has_id && !b.has_id)
        begin
            a_less = 1'b1;
        end
        else if (!a.has_id || !b.has_id)
        begin
            a_less = 1'b0;
        end
        else
        begin
            a_less = da < db;
        end
    end

endmodule

[rtl/xor_distance_shortlist_core.sv]
// xor_distance_shortlist_core: top level, sequencer around the entry memory and comparator
// depends on xds_pkg, xds_if, xds_slot_ram, xds_dist_cmp

// Keeps up to 64 peers sorted by xor distance of their node id from a 160-bit
// target; peers without an id sort last. One request is taken at a time: the
// request port is ready only while the sequencer is idle, and a finished result
// sits in an output register so the next request can be taken while it waits.
// All entries live in a single-port-write memory with a registered read, and a
// single distance comparator serves both the insert scan and the id-upgrade bubble;
// the scans and the shift walk the memory at one entry per cycle. An insert scans the
// n entries in use, then decides, shifts and writes, or moves an id-upgraded entry
// forward one position at a time; a full-list reject stops after the scan and the
// decide; pick scans up to n entries, complete reads and writes one entry, clear and
// a wrong-family reject skip the list; every request then rechecks the first
// k = min(top_count, n) entries for walk completion and posts the result.
// Configuration writes are always accepted and must only be issued while idle.

module xor_distance_shortlist_core (
    input  logic       clk,
    input  logic       rst_n,
    xds_in_if.sink     in_ch,
    xds_out_if.source  out_ch,
    xds_cfg_if.sink    cfg_ch
);

    localparam int IDX_W = xds_pkg::IDX_W;
    localparam int CNT_W = xds_pkg::CNT_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_SCAN,
        S_INS_DECIDE,
        S_SHIFT,
        S_INS_WR,
        S_BUB_RD,
        S_BUB_CMP,
        S_BUB_WR,
        S_PICK_SCAN,
        S_CPL_RD,
        S_CPL_WR,
        S_DONE_INIT,
        S_DONE_SCAN,
        S_FINISH
    } state_t;

    // sequencer and list state
    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          used_reg, used_next;
    logic                      pend_v_reg, pend_v_next;
    logic [IDX_W-1:0]          pend_slot_reg, pend_slot_next;
    logic [7:0]                hops_reg, hops_next;

    // configuration
    logic [xds_pkg::ID_W-1:0]  target_reg, target_next;
    logic                      fam_reg, fam_next;
    logic [7:0]                hop_limit_reg, hop_limit_next;
    logic [6:0]                top_count_reg, top_count_next;

    // request under work
    xds_pkg::slot_t            cand_reg, cand_next;
    logic                      resp_reg, resp_next;

    // scan pipeline: issue pointer, then read data tagged with its slot
    logic [CNT_W-1:0]          scan_reg, scan_next;
    logic                      pv_reg, pv_next;
    logic [IDX_W-1:0]          pidx_reg, pidx_next;

    // insert bookkeeping
    logic [CNT_W-1:0]          pos_reg, pos_next;
    logic                      pos_found_reg, pos_found_next;
    logic [IDX_W-1:0]          ev_reg, ev_next;
    logic                      ev_found_reg, ev_found_next;
    logic [CNT_W-1:0]          left_reg, left_next;
    logic [IDX_W-1:0]          cur_reg, cur_next;
    xds_pkg::slot_t            ent_reg, ent_next;

    // top-k completion check
    logic [CNT_W-1:0]          k_reg, k_next;
    logic                      topk_reg, topk_next;

    // result fields
    xds_pkg::status_t          st_reg, st_next;
    logic [CNT_W-1:0]          idx_reg, idx_next;
    logic [63:0]               oah_reg, oah_next;
    logic [63:0]               oal_reg, oal_next;
    logic [15:0]               oport_reg, oport_next;

    // output register
    logic                      ov_reg, ov_next;
    logic [3:0]                o_status_reg, o_status_next;
    logic [CNT_W-1:0]          o_index_reg, o_index_next;
    logic [63:0]               o_ah_reg, o_ah_next;
    logic [63:0]               o_al_reg, o_al_next;
    logic [15:0]               o_port_reg, o_port_next;
    logic [CNT_W-1:0]          o_count_reg, o_count_next;
    logic                      o_done_reg, o_done_next;
    logic [7:0]                o_hops_reg, o_hops_next;

    // memory and comparator hookup
    logic                      mem_we;
    logic [IDX_W-1:0]          mem_waddr;
    xds_pkg::slot_t            mem_wdata;
    logic [IDX_W-1:0]          mem_raddr;
    xds_pkg::slot_t            mem_rdata;
    xds_pkg::slot_t            cmp_a;
    logic                      cmp_less;

    logic                      in_xfer;
    logic                      addr_match;
    logic [CNT_W-1:0]          ins_pos;
    logic [CNT_W-1:0]          cur_ext;
    xds_pkg::slot_t            cand_in;

    xds_slot_ram u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // candidate during insert scan, moving entry during the bubble
    assign cmp_a = (state_reg == S_BUB_CMP) ? ent_reg : cand_reg;

    xds_dist_cmp u_cmp (
        .target (target_reg),
        .a      (cmp_a),
        .b      (mem_rdata),
        .a_less (cmp_less)
    );

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign in_xfer      = in_ch.valid && in_ch.ready;
    assign cfg_ch.ready = 1'b1;

    assign out_ch.valid            = ov_reg;
    assign out_ch.status           = o_status_reg;
    assign out_ch.entry_index      = o_index_reg;
    assign out_ch.out_address_high = o_ah_reg;
    assign out_ch.out_address_low  = o_al_reg;
    assign out_ch.out_port         = o_port_reg;
    assign out_ch.entry_count      = o_count_reg;
    assign out_ch.walk_done        = o_done_reg;
    assign out_ch.hop_count        = o_hops_reg;

    assign addr_match = (mem_rdata.addr_high == cand_reg.addr_high)
                     && (mem_rdata.addr_low == cand_reg.addr_low)
                     && (mem_rdata.port == cand_reg.port);
    assign ins_pos = pos_found_reg ? pos_reg : used_reg;
    assign cur_ext = CNT_W'(cur_reg);

    // candidate entry as offered; ipv4 keeps the low 32 address bits only
    always_comb
    begin
        cand_in           = '0;
        cand_in.addr_high = in_ch.peer_is_v6 ? in_ch.peer_address_high : 64'd0;
        cand_in.addr_low  = in_ch.peer_is_v6 ? in_ch.peer_address_low
                                             : {32'd0, in_ch.peer_address_low[31:0]};
        cand_in.port      = in_ch.peer_port;
        cand_in.pstate    = xds_pkg::PROBE_FRESH;
        if (in_ch.id_present)
        begin
            cand_in.has_id    = 1'b1;
            cand_in.id_high   = in_ch.node_id_high;
            cand_in.id_middle = in_ch.node_id_middle;
            cand_in.id_low    = in_ch.node_id_low;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        pend_v_next    = pend_v_reg;
        pend_slot_next = pend_slot_reg;
        hops_next      = hops_reg;
        target_next    = target_reg;
        fam_next       = fam_reg;
        hop_limit_next = hop_limit_reg;
        top_count_next = top_count_reg;
        cand_next      = cand_reg;
        resp_next      = resp_reg;
        scan_next      = scan_reg;
        pv_next        = pv_reg;
        pidx_next      = pidx_reg;
        pos_next       = pos_reg;
        pos_found_next = pos_found_reg;
        ev_next        = ev_reg;
        ev_found_next  = ev_found_reg;
        left_next      = left_reg;
        cur_next       = cur_reg;
        ent_next       = ent_reg;
        k_next         = k_reg;
        topk_next      = topk_reg;
        st_next        = st_reg;
        idx_next       = idx_reg;
        oah_next       = oah_reg;
        oal_next       = oal_reg;
        oport_next     = oport_reg;
        ov_next        = ov_reg;
        o_status_next  = o_status_reg;
        o_index_next   = o_index_reg;
        o_ah_next      = o_ah_reg;
        o_al_next      = o_al_reg;
        o_port_next    = o_port_reg;
        o_count_next   = o_count_reg;
        o_done_next    = o_done_reg;
        o_hops_next    = o_hops_reg;
        mem_we         = 1'b0;
        mem_waddr      = cur_reg;
        mem_wdata      = ent_reg;
        mem_raddr      = scan_reg[IDX_W-1:0];

        // result taken downstream
        if (ov_reg && out_ch.ready)
        begin
            ov_next = 1'b0;
        end

        // configuration register writes
        if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                xds_pkg::REG_TARGET_HIGH:   target_next[159:128] = cfg_ch.data[31:0];
                xds_pkg::REG_TARGET_MIDDLE: target_next[127:64]  = cfg_ch.data;
                xds_pkg::REG_TARGET_LOW:    target_next[63:0]    = cfg_ch.data;
                xds_pkg::REG_OWN_FAMILY:    fam_next             = cfg_ch.data[0];
                xds_pkg::REG_HOP_LIMIT:     hop_limit_next       = cfg_ch.data[7:0];
                xds_pkg::REG_TOP_COUNT:     top_count_next       = cfg_ch.data[6:0];
                default:                    ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    cand_next      = cand_in;
                    resp_next      = in_ch.responded;
                    idx_next       = '0;
                    oah_next       = '0;
                    oal_next       = '0;
                    oport_next     = '0;
                    scan_next      = '0;
                    pv_next        = 1'b0;
                    pos_found_next = 1'b0;
                    ev_found_next  = 1'b0;
                    state_next     = S_DONE_INIT;
                    case (in_ch.mode)
                        xds_pkg::MODE_INSERT:
                        begin
                            if (in_ch.peer_is_v6 != fam_reg)
                            begin
                                st_next = xds_pkg::ST_WRONG_FAMILY;
                            end
                            else
                            begin
                                st_next    = xds_pkg::ST_INSERTED;
                                state_next = S_INS_SCAN;
                            end
                        end
                        xds_pkg::MODE_PICK:
                        begin
                            if (pend_v_reg)
                            begin
                                st_next = xds_pkg::ST_BUSY;
                            end
                            else
                            begin
                                st_next    = xds_pkg::ST_NONE_FRESH;
                                state_next = S_PICK_SCAN;
                            end
                        end
                        xds_pkg::MODE_COMPLETE:
                        begin
                            if (!pend_v_reg)
                            begin
                                st_next = xds_pkg::ST_NONE_PENDING;
                            end
                            else
                            begin
                                st_next     = xds_pkg::ST_COMPLETED;
                                idx_next    = CNT_W'(pend_slot_reg);
                                pend_v_next = 1'b0;
                                if (CNT_W'(pend_slot_reg) < used_reg)
                                begin
                                    state_next = S_CPL_RD;
                                end
                            end
                        end
                        default:
                        begin
                            st_next        = xds_pkg::ST_CLEARED;
                            used_next      = '0;
                            pend_v_next    = 1'b0;
                            pend_slot_next = '0;
                            hops_next      = '0;
                        end
                    endcase
                end
            end

            // one entry a cycle: dedupe, insert position, last fresh entry
            S_INS_SCAN:
            begin
                if (scan_reg < used_reg)
                begin
                    mem_raddr = scan_reg[IDX_W-1:0];
                    pv_next   = 1'b1;
                    pidx_next = scan_reg[IDX_W-1:0];
                    scan_next = scan_reg + 1'b1;
                end
                else
                begin
                    pv_next = 1'b0;
                end
                if (pv_reg)
                begin
                    if (addr_match)
                    begin
                        pv_next = 1'b0;
                        st_next = xds_pkg::ST_PRESENT;
                        if (cand_reg.has_id && !mem_rdata.has_id)
                        begin
                            // learn the id, then bubble toward the front
                            ent_next           = mem_rdata;
                            ent_next.has_id    = 1'b1;
                            ent_next.id_high   = cand_reg.id_high;
                            ent_next.id_middle = cand_reg.id_middle;
                            ent_next.id_low    = cand_reg.id_low;
                            cur_next           = pidx_reg;
                            state_next         = (pidx_reg != '0) ? S_BUB_RD : S_BUB_WR;
                        end
                        else
                        begin
                            idx_next   = CNT_W'(pidx_reg);
                            state_next = S_DONE_INIT;
                        end
                    end
                    else
                    begin
                        if (!pos_found_reg && cmp_less)
                        begin
                            pos_next       = CNT_W'(pidx_reg);
                            pos_found_next = 1'b1;
                        end
                        if (mem_rdata.pstate == xds_pkg::PROBE_FRESH)
                        begin
                            ev_next       = pidx_reg;
                            ev_found_next = 1'b1;
                        end
                    end
                end
                else if (scan_reg >= used_reg)
                begin
                    state_next = S_INS_DECIDE;
                end
            end

            // pick the span to shift: up to the evicted entry when full
            S_INS_DECIDE:
            begin
                pos_next = ins_pos;
                pv_next  = 1'b0;
                if (used_reg == CNT_W'(xds_pkg::LIST_DEPTH))
                begin
                    if (!ev_found_reg || ins_pos > CNT_W'(ev_reg))
                    begin
                        st_next    = xds_pkg::ST_REJECTED_FULL;
                        state_next = S_DONE_INIT;
                    end
                    else
                    begin
                        if (pend_v_reg && CNT_W'(pend_slot_reg) >= ins_pos
                            && pend_slot_reg < ev_reg)
                        begin
                            pend_slot_next = pend_slot_reg + 1'b1;
                        end
                        scan_next  = CNT_W'(ev_reg);
                        left_next  = CNT_W'(ev_reg) - ins_pos;
                        state_next = S_SHIFT;
                    end
                end
                else
                begin
                    if (ins_pos < used_reg && pend_v_reg
                        && CNT_W'(pend_slot_reg) >= ins_pos)
                    begin
                        pend_slot_next = pend_slot_reg + 1'b1;
                    end
                    scan_next  = used_reg;
                    left_next  = used_reg - ins_pos;
                    used_next  = used_reg + 1'b1;
                    state_next = S_SHIFT;
                end
            end

            // move entries up one slot, highest first, one per cycle
            S_SHIFT:
            begin
                if (left_reg != '0)
                begin
                    mem_raddr = IDX_W'(scan_reg - 1'b1);
                    pv_next   = 1'b1;
                    pidx_next = IDX_W'(scan_reg - 1'b1);
                    scan_next = scan_reg - 1'b1;
                    left_next = left_reg - 1'b1;
                end
                else
                begin
                    pv_next = 1'b0;
                end
                if (pv_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pidx_reg + 1'b1;
                    mem_wdata = mem_rdata;
                end
                if (left_reg == '0 && !pv_reg)
                begin
                    state_next = S_INS_WR;
                end
            end

            S_INS_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg[IDX_W-1:0];
                mem_wdata  = cand_reg;
                idx_next   = pos_reg;
                state_next = S_DONE_INIT;
            end

            S_BUB_RD:
            begin
                mem_raddr  = cur_reg - 1'b1;
                state_next = S_BUB_CMP;
            end

            // the moving entry stays in ent_reg until it settles
            S_BUB_CMP:
            begin
                if (cmp_less)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cur_reg;
                    mem_wdata = mem_rdata;
                    if (pend_v_reg)
                    begin
                        if (pend_slot_reg == cur_reg)
                        begin
                            pend_slot_next = cur_reg - 1'b1;
                        end
                        else if (pend_slot_reg == cur_reg - 1'b1)
                        begin
                            pend_slot_next = cur_reg;
                        end
                    end
                    cur_next   = cur_reg - 1'b1;
                    state_next = (cur_reg - 1'b1 != '0) ? S_BUB_RD : S_BUB_WR;
                end
                else
                begin
                    state_next = S_BUB_WR;
                end
            end

            S_BUB_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = cur_reg;
                mem_wdata  = ent_reg;
                idx_next   = cur_ext;
                state_next = S_DONE_INIT;
            end

            // first fresh entry goes in flight
            S_PICK_SCAN:
            begin
                if (scan_reg < used_reg)
                begin
                    mem_raddr = scan_reg[IDX_W-1:0];
                    pv_next   = 1'b1;
                    pidx_next = scan_reg[IDX_W-1:0];
                    scan_next = scan_reg + 1'b1;
                end
                else
                begin
                    pv_next = 1'b0;
                end
                if (pv_reg && mem_rdata.pstate == xds_pkg::PROBE_FRESH)
                begin
                    pv_next          = 1'b0;
                    mem_we           = 1'b1;
                    mem_waddr        = pidx_reg;
                    mem_wdata        = mem_rdata;
                    mem_wdata.pstate = xds_pkg::PROBE_INFLIGHT;
                    pend_v_next      = 1'b1;
                    pend_slot_next   = pidx_reg;
                    if (hops_reg != 8'hFF)
                    begin
                        hops_next = hops_reg + 1'b1;
                    end
                    oah_next   = mem_rdata.addr_high;
                    oal_next   = mem_rdata.addr_low;
                    oport_next = mem_rdata.port;
                    idx_next   = CNT_W'(pidx_reg);
                    st_next    = xds_pkg::ST_PICKED;
                    state_next = S_DONE_INIT;
                end
                else if (!pv_reg && scan_reg >= used_reg)
                begin
                    state_next = S_DONE_INIT;
                end
            end

            S_CPL_RD:
            begin
                mem_raddr  = pend_slot_reg;
                state_next = S_CPL_WR;
            end

            // responder id only fills a missing id, no re-sort
            S_CPL_WR:
            begin
                mem_we           = 1'b1;
                mem_waddr        = pend_slot_reg;
                mem_wdata        = mem_rdata;
                mem_wdata.pstate = resp_reg ? xds_pkg::PROBE_RESPONDED
                                            : xds_pkg::PROBE_FAILED;
                if (resp_reg && cand_reg.has_id && !mem_rdata.has_id)
                begin
                    mem_wdata.has_id    = 1'b1;
                    mem_wdata.id_high   = cand_reg.id_high;
                    mem_wdata.id_middle = cand_reg.id_middle;
                    mem_wdata.id_low    = cand_reg.id_low;
                end
                state_next = S_DONE_INIT;
            end

            S_DONE_INIT:
            begin
                k_next     = (CNT_W'(top_count_reg) < used_reg) ? CNT_W'(top_count_reg)
                                                                : used_reg;
                topk_next  = (((CNT_W'(top_count_reg) < used_reg) ? CNT_W'(top_count_reg)
                                                                  : used_reg) != '0);
                scan_next  = '0;
                pv_next    = 1'b0;
                state_next = S_DONE_SCAN;
            end

            // every one of the first k entries must be responded or failed
            S_DONE_SCAN:
            begin
                if (topk_reg && scan_reg < k_reg)
                begin
                    mem_raddr = scan_reg[IDX_W-1:0];
                    pv_next   = 1'b1;
                    scan_next = scan_reg + 1'b1;
                end
                else
                begin
                    pv_next = 1'b0;
                end
                if (pv_reg && topk_reg
                    && (mem_rdata.pstate == xds_pkg::PROBE_FRESH
                        || mem_rdata.pstate == xds_pkg::PROBE_INFLIGHT))
                begin
                    topk_next = 1'b0;
                end
                if (!topk_reg || (scan_reg >= k_reg && !pv_reg))
                begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (!ov_reg || out_ch.ready)
                begin
                    ov_next       = 1'b1;
                    o_status_next = st_reg;
                    o_index_next  = idx_reg;
                    o_ah_next     = oah_reg;
                    o_al_next     = oal_reg;
                    o_port_next   = oport_reg;
                    o_count_next  = used_reg;
                    o_done_next   = topk_reg || (hops_reg >= hop_limit_reg);
                    o_hops_next   = hops_reg;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            pend_v_reg    <= 1'b0;
            pend_slot_reg <= '0;
            hops_reg      <= '0;
            target_reg    <= '0;
            fam_reg       <= 1'b0;
            hop_limit_reg <= xds_pkg::HOP_LIMIT_RESET;
            top_count_reg <= xds_pkg::TOP_COUNT_RESET;
            pv_reg        <= 1'b0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            pend_v_reg    <= pend_v_next;
            pend_slot_reg <= pend_slot_next;
            hops_reg      <= hops_next;
            target_reg    <= target_next;
            fam_reg       <= fam_next;
            hop_limit_reg <= hop_limit_next;
            top_count_reg <= top_count_next;
            pv_reg        <= pv_next;
            ov_reg        <= ov_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        cand_reg      <= cand_next;
        resp_reg      <= resp_next;
        scan_reg      <= scan_next;
        pidx_reg      <= pidx_next;
        pos_reg       <= pos_next;
        pos_found_reg <= pos_found_next;
        ev_reg        <= ev_next;
        ev_found_reg  <= ev_found_next;
        left_reg      <= left_next;
        cur_reg       <= cur_next;
        ent_reg       <= ent_next;
        k_reg         <= k_next;
        topk_reg      <= topk_next;
        st_reg        <= st_next;
        idx_reg       <= idx_next;
        oah_reg       <= oah_next;
        oal_reg       <= oal_next;
        oport_reg     <= oport_next;
        o_status_reg  <= o_status_next;
        o_index_reg   <= o_index_next;
        o_ah_reg      <= o_ah_next;
        o_al_reg      <= o_al_next;
        o_port_reg    <= o_port_next;
        o_count_reg   <= o_count_next;
        o_done_reg    <= o_done_next;
        o_hops_reg    <= o_hops_next;
    end

    // list never overfills
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(xds_pkg::LIST_DEPTH))
        else $error("shortlist count above depth");

    // the pending probe always points at a live entry
    a_pend_live: assert property (@(posedge clk) disable iff (!rst_n)
        pend_v_reg |-> (CNT_W'(pend_slot_reg) < used_reg))
        else $error("pending slot outside the list");

    // one request at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ch.ready)
        else $error("request port ready while busy");

endmodule

[tb/xds_tb_if.sv]
// xds_tb_if: testbench package with the request and result records of the shortlist
// depends on xds_pkg; the channel interfaces come from rtl/xds_if.sv
`timescale 1ns / 100ps

package xds_tb_pkg;

    // one offered request as the testbench builds it
    typedef struct {
        xds_pkg::mode_t mode;
        logic           is_v6;
        logic [63:0]    addr_high;
        logic [63:0]    addr_low;
        logic [15:0]    port;
        logic           id_present;
        logic [31:0]    id_high;
        logic [63:0]    id_middle;
        logic [63:0]    id_low;
        logic           responded;
    } request_t;

    // one result as the shortlist reports it
    typedef struct {
        xds_pkg::status_t status;
        logic [6:0]       index;
        logic [63:0]      addr_high;
        logic [63:0]      addr_low;
        logic [15:0]      port;
        logic [6:0]       count;
        logic             done;
        logic [7:0]       hops;
    } result_t;

endpackage

[tb/xor_distance_shortlist_core_tb.sv]
// xor_distance_shortlist_core_tb: directed and random check of the xor distance shortlist
// depends on xds_pkg, xds_if, xds_tb_pkg and the core; results are compared with a local model
`timescale 1ns / 100ps

module xor_distance_shortlist_core_tb;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #1 clk = ~clk;

    xds_in_if  in_ch ();
    xds_out_if out_ch ();
    xds_cfg_if cfg_ch ();

    xor_distance_shortlist_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg_ch (cfg_ch.sink)
    );

    // shadow of the shortlist state
    xds_pkg::slot_t shadow [xds_pkg::LIST_DEPTH];
    int             used_n;
    bit             probe_open;
    int             probe_slot;
    int             hops_n;
    logic [159:0]   walk_target;
    logic           accept_v6;
    logic [7:0]     hop_cap;
    logic [6:0]     top_k;

    xds_tb_pkg::result_t expected_q [$];
    int          error_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          idle_cycles = 0;
    localparam int WATCHDOG_LIMIT = 20000;

    // reused pools so dedupe and id upgrades actually hit
    logic [63:0] addr_pool [8];
    logic [15:0] port_pool [4];

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // signed compare of xor distance, ids missing sort last
    function automatic int distance_order(input xds_pkg::slot_t a, input xds_pkg::slot_t b);
        logic [159:0] da, db;
        if (a.has_id && !b.has_id) return -1;
        if (!a.has_id && b.has_id) return 1;
        if (!a.has_id) return 0;
        da = ({a.id_high, a.id_middle, a.id_low} ^ walk_target) & xds_pkg::ID_MASK;
        db = ({b.id_high, b.id_middle, b.id_low} ^ walk_target) & xds_pkg::ID_MASK;
        if (da == db) return 0;
        return (da < db) ? -1 : 1;
    endfunction

    function automatic bit walk_finished();
        int k;
        bit all_term;
        k = (int'(top_k) < used_n) ? int'(top_k) : used_n;
        all_term = (k != 0);
        for (int i = 0; i < k; i++)
            if (shadow[i].pstate == xds_pkg::PROBE_FRESH
                || shadow[i].pstate == xds_pkg::PROBE_INFLIGHT)
                all_term = 0;
        return all_term || (hops_n >= int'(hop_cap));
    endfunction

    function automatic xds_pkg::status_t shortlist_insert(input xds_tb_pkg::request_t rq,
                                                          output int where);
        xds_pkg::slot_t c, t;
        int pos, ev, i;
        bit found;
        where = 0;
        if (rq.is_v6 != accept_v6) return xds_pkg::ST_WRONG_FAMILY;
        c = '0;
        c.addr_high = rq.is_v6 ? rq.addr_high : 64'd0;
        c.addr_low = rq.is_v6 ? rq.addr_low : {32'd0, rq.addr_low[31:0]};
        c.port = rq.port;
        c.pstate = xds_pkg::PROBE_FRESH;
        if (rq.id_present)
        begin
            c.has_id = 1'b1;
            c.id_high = rq.id_high;
            c.id_middle = rq.id_middle;
            c.id_low = rq.id_low;
        end
        for (i = 0; i < used_n; i++)
        begin
            if (shadow[i].addr_high != c.addr_high || shadow[i].addr_low != c.addr_low ||
                shadow[i].port != c.port)
                continue;
            if (c.has_id && !shadow[i].has_id)
            begin
                shadow[i].id_high = c.id_high;
                shadow[i].id_middle = c.id_middle;
                shadow[i].id_low = c.id_low;
                shadow[i].has_id = 1'b1;
                // bubble the upgraded entry left
                while (i > 0 && distance_order(shadow[i], shadow[i-1]) < 0)
                begin
                    t = shadow[i-1];
                    shadow[i-1] = shadow[i];
                    shadow[i] = t;
                    if (probe_open)
                    begin
                        if (probe_slot == i) probe_slot = i - 1;
                        else if (probe_slot == i - 1) probe_slot = i;
                    end
                    i--;
                end
            end
            where = i;
            return xds_pkg::ST_PRESENT;
        end
        pos = used_n;
        for (i = 0; i < used_n; i++)
            if (distance_order(c, shadow[i]) < 0)
            begin
                pos = i;
                break;
            end
        if (used_n >= xds_pkg::LIST_DEPTH)
        begin
            ev = used_n;
            found = 0;
            while (ev > 0)
            begin
                ev--;
                if (shadow[ev].pstate == xds_pkg::PROBE_FRESH)
                begin
                    found = 1;
                    break;
                end
            end
            if (!found || pos > ev) return xds_pkg::ST_REJECTED_FULL;
            for (i = ev; i > pos; i--) shadow[i] = shadow[i-1];
            if (probe_open && probe_slot >= pos && probe_slot < ev) probe_slot++;
            shadow[pos] = c;
            where = pos;
            return xds_pkg::ST_INSERTED;
        end
        for (i = used_n; i > pos; i--) shadow[i] = shadow[i-1];
        if (probe_open && probe_slot >= pos && pos < used_n) probe_slot++;
        shadow[pos] = c;
        used_n++;
        where = pos;
        return xds_pkg::ST_INSERTED;
    endfunction

    // advance the shadow by one request and queue the result it must give
    task automatic predict_result(input xds_tb_pkg::request_t rq);
        xds_tb_pkg::result_t r;
        int where;
        r = '{status: xds_pkg::ST_INSERTED, default: '0};
        case (rq.mode)
            xds_pkg::MODE_INSERT:
            begin
                r.status = shortlist_insert(rq, where);
                r.index = 7'(where);
            end
            xds_pkg::MODE_PICK:
            begin
                if (probe_open) r.status = xds_pkg::ST_BUSY;
                else
                begin
                    r.status = xds_pkg::ST_NONE_FRESH;
                    for (int i = 0; i < used_n; i++)
                    begin
                        if (shadow[i].pstate != xds_pkg::PROBE_FRESH) continue;
                        shadow[i].pstate = xds_pkg::PROBE_INFLIGHT;
                        probe_open = 1;
                        probe_slot = i;
                        if (hops_n < 255) hops_n++;
                        r.addr_high = shadow[i].addr_high;
                        r.addr_low = shadow[i].addr_low;
                        r.port = shadow[i].port;
                        r.index = 7'(i);
                        r.status = xds_pkg::ST_PICKED;
                        break;
                    end
                end
            end
            xds_pkg::MODE_COMPLETE:
            begin
                if (!probe_open) r.status = xds_pkg::ST_NONE_PENDING;
                else
                begin
                    probe_open = 0;
                    if (probe_slot < used_n)
                    begin
                        shadow[probe_slot].pstate = rq.responded ? xds_pkg::PROBE_RESPONDED
                                                                 : xds_pkg::PROBE_FAILED;
                        if (rq.responded && rq.id_present && !shadow[probe_slot].has_id)
                        begin
                            shadow[probe_slot].id_high = rq.id_high;
                            shadow[probe_slot].id_middle = rq.id_middle;
                            shadow[probe_slot].id_low = rq.id_low;
                            shadow[probe_slot].has_id = 1'b1;
                        end
                    end
                    r.index = 7'(probe_slot);
                    r.status = xds_pkg::ST_COMPLETED;
                end
            end
            default:
            begin
                used_n = 0;
                probe_open = 0;
                probe_slot = 0;
                hops_n = 0;
                r.status = xds_pkg::ST_CLEARED;
            end
        endcase
        r.count = 7'(used_n);
        r.done = walk_finished();
        r.hops = 8'(hops_n);
        expected_q.push_back(r);
    endtask

    // one request transfer, with random sender gaps; valid stays up until the next
    // request or a drain takes it down
    task automatic send_request(input xds_tb_pkg::request_t rq);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode <= rq.mode;
        in_ch.peer_is_v6 <= rq.is_v6;
        in_ch.peer_address_high <= rq.addr_high;
        in_ch.peer_address_low <= rq.addr_low;
        in_ch.peer_port <= rq.port;
        in_ch.id_present <= rq.id_present;
        in_ch.node_id_high <= rq.id_high;
        in_ch.node_id_middle <= rq.id_middle;
        in_ch.node_id_low <= rq.id_low;
        in_ch.responded <= rq.responded;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        predict_result(rq);
    endtask

    task automatic write_register(input xds_pkg::reg_idx_t idx, input logic [63:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        case (idx)
            xds_pkg::REG_TARGET_HIGH:   walk_target[159:128] = value[31:0];
            xds_pkg::REG_TARGET_MIDDLE: walk_target[127:64] = value;
            xds_pkg::REG_TARGET_LOW:    walk_target[63:0] = value;
            xds_pkg::REG_OWN_FAMILY:    accept_v6 = value[0];
            xds_pkg::REG_HOP_LIMIT:     hop_cap = value[7:0];
            xds_pkg::REG_TOP_COUNT:     top_k = value[6:0];
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // drop the request valid, wait for all results, then idle before touching registers
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (260) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic xds_tb_pkg::request_t random_request(input int mix);
        xds_tb_pkg::request_t rq;
        int r;
        r = $urandom_range(99);
        // mostly inserts, picks and completes; clears are rare so the list fills up
        if (r < 55) rq.mode = xds_pkg::MODE_INSERT;
        else if (r < 75) rq.mode = xds_pkg::MODE_PICK;
        else if (r < 98) rq.mode = xds_pkg::MODE_COMPLETE;
        else rq.mode = xds_pkg::MODE_CLEAR;
        rq.is_v6 = ($urandom_range(9) == 0) ? ~accept_v6 : accept_v6;
        if ($urandom_range(1) == 0)
        begin
            rq.addr_high = addr_pool[$urandom_range(7)];
            rq.addr_low = addr_pool[$urandom_range(7)];
            rq.port = port_pool[$urandom_range(3)];
        end
        else
        begin
            rq.addr_high = rand64();
            rq.addr_low = rand64();
            rq.port = 16'($urandom);
        end
        rq.id_present = ($urandom_range(3) != 0);
        rq.id_high = (mix == 0) ? walk_target[159:128] ^ $urandom_range(3) : $urandom;
        rq.id_middle = rand64();
        rq.id_low = rand64();
        rq.responded = 1'($urandom_range(1));
        return rq;
    endfunction

    // result side: random stalls and the field by field compare
    always @(posedge clk)
    begin
        xds_tb_pkg::result_t want;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    report("unexpected result", 64'(out_ch.status), 64'd0);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (out_ch.status != want.status)
                        report("status", 64'(out_ch.status), 64'(want.status));
                    if (out_ch.entry_index != want.index)
                        report("entry_index", 64'(out_ch.entry_index), 64'(want.index));
                    if (out_ch.out_address_high != want.addr_high)
                        report("out_address_high", out_ch.out_address_high, want.addr_high);
                    if (out_ch.out_address_low != want.addr_low)
                        report("out_address_low", out_ch.out_address_low, want.addr_low);
                    if (out_ch.out_port != want.port)
                        report("out_port", 64'(out_ch.out_port), 64'(want.port));
                    if (out_ch.entry_count != want.count)
                        report("entry_count", 64'(out_ch.entry_count), 64'(want.count));
                    if (out_ch.walk_done != want.done)
                        report("walk_done", 64'(out_ch.walk_done), 64'(want.done));
                    if (out_ch.hop_count != want.hops)
                        report("hop_count", 64'(out_ch.hop_count), 64'(want.hops));
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("[xor_distance_shortlist_core] ERROR");
            $finish;
        end
    end

    task automatic test_directed();
        xds_tb_pkg::request_t rq;
        rq = '{mode: xds_pkg::MODE_PICK, default: '0};
        send_request(rq);                              // pick on empty list
        rq.mode = xds_pkg::MODE_COMPLETE;
        send_request(rq);                              // complete with nothing pending
        rq = '{mode: xds_pkg::MODE_INSERT, addr_low: '1, addr_high: '1, port: '1,
               default: '0};
        send_request(rq);                              // ipv4 keeps low 32 bits only, no id
        rq.is_v6 = 1'b1;
        send_request(rq);                              // wrong family
        rq = '{mode: xds_pkg::MODE_INSERT, addr_low: 64'hFFFF_FFFF, port: '1,
               id_present: 1'b1, id_high: '1, id_middle: '1, id_low: '1, default: '0};
        send_request(rq);                              // duplicate learns its id
        rq.id_high = '0;
        send_request(rq);                              // known id kept
        rq = '{mode: xds_pkg::MODE_INSERT, addr_low: 64'd5, id_present: 1'b1, default: '0};
        send_request(rq);                              // zero distance, goes first
        rq.addr_low = 64'd6;
        send_request(rq);                              // tie, placed after
        rq = '{mode: xds_pkg::MODE_PICK, default: '0};
        send_request(rq);
        send_request(rq);                              // busy
        rq = '{mode: xds_pkg::MODE_COMPLETE, responded: 1'b1, id_present: 1'b1, default: '0};
        send_request(rq);
        rq = '{mode: xds_pkg::MODE_PICK, default: '0};
        send_request(rq);
        rq = '{mode: xds_pkg::MODE_COMPLETE, default: '0};
        send_request(rq);                              // failed probe
        rq.mode = xds_pkg::MODE_CLEAR;
        send_request(rq);
    endtask

    // fill past 64 entries so evictions and full rejects happen
    task automatic test_full_list();
        xds_tb_pkg::request_t rq;
        for (int n = 0; n < 90; n++)
        begin
            rq = random_request(1);
            rq.mode = (n % 7 == 3) ? xds_pkg::MODE_PICK
                    : (n % 7 == 5) ? xds_pkg::MODE_COMPLETE : xds_pkg::MODE_INSERT;
            rq.is_v6 = accept_v6;
            rq.addr_low = rand64();
            send_request(rq);
        end
    endtask

    task automatic test_random(input int count, input int mix);
        for (int n = 0; n < count; n++) send_request(random_request(mix));
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.mode = xds_pkg::MODE_INSERT;
        in_ch.peer_is_v6 = 1'b0;
        in_ch.peer_address_high = '0;
        in_ch.peer_address_low = '0;
        in_ch.peer_port = '0;
        in_ch.id_present = 1'b0;
        in_ch.node_id_high = '0;
        in_ch.node_id_middle = '0;
        in_ch.node_id_low = '0;
        in_ch.responded = 1'b0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = xds_pkg::REG_TARGET_HIGH;
        cfg_ch.data = '0;
        used_n = 0;
        probe_open = 0;
        probe_slot = 0;
        hops_n = 0;
        walk_target = '0;
        accept_v6 = 1'b0;
        hop_cap = xds_pkg::HOP_LIMIT_RESET;
        top_k = xds_pkg::TOP_COUNT_RESET;
        for (int i = 0; i < 8; i++)
            addr_pool[i] = (i == 0) ? 64'd0 : (i == 1) ? '1 : rand64();
        for (int i = 0; i < 4; i++)
            port_pool[i] = (i == 0) ? 16'd0 : (i == 1) ? '1 : 16'($urandom);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 8;
        recv_stall_pct = 53;
        test_directed();
        drain();

        // extreme settings: small top-k and hop limit
        write_register(xds_pkg::REG_TOP_COUNT, 64'd1);
        write_register(xds_pkg::REG_HOP_LIMIT, 64'd1);
        test_random(40, 1);
        drain();

        write_register(xds_pkg::REG_TARGET_HIGH, rand64());
        write_register(xds_pkg::REG_TARGET_MIDDLE, rand64());
        write_register(xds_pkg::REG_TARGET_LOW, rand64());
        write_register(xds_pkg::REG_TOP_COUNT, 64'd64);
        write_register(xds_pkg::REG_HOP_LIMIT, 64'd255);
        test_full_list();
        test_random(250, 0);
        drain();

        send_idle_pct = 53;
        recv_stall_pct = 8;
        write_register(xds_pkg::REG_OWN_FAMILY, 64'd1);
        write_register(xds_pkg::REG_TOP_COUNT, 64'd0);
        write_register(xds_pkg::REG_HOP_LIMIT, 64'd0);
        test_random(200, 1);
        drain();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_register(xds_pkg::REG_OWN_FAMILY, 64'd0);
        write_register(xds_pkg::REG_TARGET_HIGH, 64'hFFFF_FFFF);
        write_register(xds_pkg::REG_TARGET_MIDDLE, '1);
        write_register(xds_pkg::REG_TARGET_LOW, '1);
        write_register(xds_pkg::REG_TOP_COUNT, 64'd20);
        write_register(xds_pkg::REG_HOP_LIMIT, 64'd48);
        test_random(220, 0);
        drain();

        if (error_count == 0)
            $display("[xor_distance_shortlist_core] OK");
        else
            $display("[xor_distance_shortlist_core] ERROR");
        $finish;
    end
endmodule
